// ----- rtl/core/apc_pkg.sv -----
// Shared widths, register addresses and saturation helpers for the allpass cascade.
`timescale 1ns / 1ps
package apc_pkg;

  localparam int SAMPLE_W = 16;
  localparam int SIG_W    = 20;
  localparam int AMT_W    = 13;
  localparam int FRAC_W   = 8;
  localparam int WHOLE_W  = AMT_W - FRAC_W;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam int MUL_A_W  = 17;
  localparam int MUL_B_W  = 21;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int WIDE_W   = 23;

  // Register index decoded from the word address bit.
  localparam logic REG_STAGE_AMOUNT = 1'b0;
  localparam logic REG_ALLPASS_COEF = 1'b1;

  // 0.5 - 0.4 of the cascade output, in Q1.15 (16384 - 13107).
  localparam logic signed [MUL_A_W-1:0] OUT_AP_GAIN = 17'sd3277;

  typedef logic signed [SIG_W-1:0]    sig_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;

  function automatic sig_t sat_sig(input logic signed [WIDE_W-1:0] v);
    sig_t r;
    if (v > WIDE_W'(524287))       r = 20'sd524287;
    else if (v < -WIDE_W'(524288)) r = -20'sd524288;
    else                           r = SIG_W'(v);
    return r;
  endfunction

  function automatic sample_t sat_sample(input logic signed [WIDE_W-1:0] v);
    sample_t r;
    if (v > WIDE_W'(32767))       r = 16'sd32767;
    else if (v < -WIDE_W'(32768)) r = -16'sd32768;
    else                          r = SAMPLE_W'(v);
    return r;
  endfunction

endpackage

// ----- rtl/core/allpass_cascade_dispersion.sv -----
// Top level of the first-order allpass dispersion cascade with its register port.
`timescale 1ns / 1ps
// Each sample runs n stages: the whole stage count, plus one partial stage when the whole
// count is below MAX_STAGES. All stages share the one multiplier: the first stage uses it
// twice, and every later stage once, since its input product is left by the stage before.
// in_stall stays high until the result is loaded, so the block takes no new sample while
// one is still in the cascade.
// Reset (synchronous, active low) clears the configuration and control registers and the per-stage valid bits.
module allpass_cascade_dispersion #(
  parameter int MAX_STAGES = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input sample channel.
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [apc_pkg::SAMPLE_W-1:0] in_sample_in,
  // Result channel.
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [apc_pkg::SAMPLE_W-1:0] out_sample_out,
  // APB-style register port.
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [apc_pkg::ADDR_W-1:0]     paddr,
  input  logic [apc_pkg::DATA_W-1:0]     pwdata,
  output logic [apc_pkg::DATA_W-1:0]     prdata,
  output logic                           pready
);

  import apc_pkg::*;

  localparam int IW = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
  localparam int KW = $clog2(MAX_STAGES + 1);

  // Sequencer codes. One stage costs MUL2 and UPD once the cascade is primed.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_ADD   = 4'd2;
  localparam logic [3:0] S_MUL2  = 4'd3;
  localparam logic [3:0] S_UPD   = 4'd4;
  localparam logic [3:0] S_BLEND = 4'd5;
  localparam logic [3:0] S_BFIN  = 4'd6;
  localparam logic [3:0] S_OUTM  = 4'd7;
  localparam logic [3:0] S_OUTF  = 4'd8;

  // Configuration registers.
  logic [AMT_W-1:0]    stage_amount_r;
  sample_t             allpass_coef_r;

  logic [3:0]          state_r, state_nxt;
  logic [KW-1:0]       k_r;
  sample_t             x_r;
  sig_t                cur_r;
  sig_t                y_r;
  sig_t                ap_r;
  logic signed [PROD_W-1:0] p_r;
  logic                out_valid_r;
  sample_t             out_sample_r;

  logic [MAX_STAGES-1:0] valid_r;
  logic                rd_valid_r;

  // Register writes happen at the access phase of a write transaction.
  logic cfg_write;
  assign cfg_write = psel & penable & pwrite & pready;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_amount_r <= '0;
      allpass_coef_r <= '0;
    end else if (cfg_write) begin
      if (paddr[2] == REG_STAGE_AMOUNT) begin
        stage_amount_r <= pwdata[AMT_W-1:0];
      end else begin
        allpass_coef_r <= pwdata[SAMPLE_W-1:0];
      end
    end
  end

  // Reads return the addressed register; byte offsets inside a word read as zero.
  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      if (paddr[2] == REG_ALLPASS_COEF) begin
        prdata = DATA_W'(allpass_coef_r);
        prdata[DATA_W-1:SAMPLE_W] = {(DATA_W - SAMPLE_W){allpass_coef_r[SAMPLE_W-1]}};
      end else begin
        prdata = DATA_W'(stage_amount_r);
      end
    end
  end

  // Stage count decode. A whole part at or past the maximum saturates and drops the fraction.
  logic [WHOLE_W-1:0] whole;
  logic [FRAC_W-1:0]  frac;
  logic               whole_ge_max;
  logic               partial;
  logic [KW-1:0]      whole_sat;
  logic [KW-1:0]      n_run;
  logic [KW-1:0]      kp1;
  logic               last_stage;

  assign whole        = stage_amount_r[AMT_W-1:FRAC_W];
  assign frac         = stage_amount_r[FRAC_W-1:0];
  assign whole_ge_max = (8'(whole) >= 8'(MAX_STAGES));
  assign partial      = !whole_ge_max;
  assign whole_sat    = whole_ge_max ? KW'(MAX_STAGES) : KW'(whole);
  assign n_run        = whole_sat + KW'(partial);
  assign kp1          = k_r + KW'(1);
  assign last_stage   = (kp1 == n_run);

  // The shared multiplier: coefficient products, the blend weight and the output gain.
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;

  always_comb begin
    mul_a = MUL_A_W'(allpass_coef_r);
    mul_b = MUL_B_W'(cur_r);
    unique case (state_r)
      S_MUL2: mul_b = MUL_B_W'(y_r);
      S_BLEND: begin
        mul_a = $signed({1'b0, {(MUL_A_W - FRAC_W - 1){1'b0}}, frac});
        mul_b = MUL_B_W'(y_r) - MUL_B_W'(cur_r);
      end
      S_OUTM: begin
        mul_a = OUT_AP_GAIN;
        mul_b = MUL_B_W'(ap_r);
      end
      default: begin
        mul_a = MUL_A_W'(allpass_coef_r);
        mul_b = MUL_B_W'(cur_r);
      end
    endcase
  end

  // Stage memory. Entries never written since reset read as zero through the valid bits.
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [IW-1:0] ram_raddr;
  sig_t          ram_wdata;
  logic [SIG_W-1:0] ram_rdata;
  sig_t          s_rd;

  assign ram_we    = (state_r == S_UPD);
  assign ram_waddr = k_r[IW-1:0];
  assign ram_raddr = (state_r == S_MUL2) ? kp1[IW-1:0] : k_r[IW-1:0];
  assign s_rd      = rd_valid_r ? $signed(ram_rdata) : '0;

  apc_ram #(
    .WIDTH(SIG_W),
    .DEPTH(MAX_STAGES)
  ) u_stage_mem (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (ram_we) begin
        valid_r[ram_waddr] <= 1'b1;
      end
      rd_valid_r <= valid_r[ram_raddr];
    end
  end

  // Datapath arithmetic around the product register.
  logic signed [WIDE_W-1:0] rnd_p;
  sig_t                     y_new;
  logic signed [PROD_W-1:0] blend_sum;
  logic signed [PROD_W-1:0] out_sum;

  assign rnd_p     = WIDE_W'((p_r + PROD_W'(16384)) >>> 15);
  assign y_new     = sat_sig(rnd_p + WIDE_W'(s_rd));
  assign ram_wdata = sat_sig(WIDE_W'(cur_r) - rnd_p);
  assign blend_sum = ((PROD_W'(cur_r) <<< FRAC_W) + p_r + PROD_W'(128)) >>> FRAC_W;
  assign out_sum   = ((PROD_W'(x_r) <<< 14) + p_r + PROD_W'(16384)) >>> 15;

  logic out_free;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_ADD;
      S_ADD:   state_nxt = S_MUL2;
      S_MUL2:  state_nxt = S_UPD;
      S_UPD: begin
        if (!last_stage) state_nxt = S_MUL2;
        else if (partial) state_nxt = S_BLEND;
        else state_nxt = S_OUTM;
      end
      S_BLEND: state_nxt = S_BFIN;
      S_BFIN:  state_nxt = S_OUTM;
      S_OUTM:  state_nxt = S_OUTF;
      S_OUTF:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_IDLE) begin
        k_r <= '0;
      end else if (state_r == S_UPD && !last_stage) begin
        k_r <= kp1;
      end
      if (state_r == S_OUTF && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      x_r   <= in_sample_in;
      cur_r <= SIG_W'(in_sample_in);
    end
    if (state_r == S_MUL || state_r == S_MUL2 || state_r == S_BLEND || state_r == S_OUTM) begin
      p_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    if (state_r == S_ADD) begin
      y_r <= y_new;
    end
    if (state_r == S_UPD) begin
      if (!last_stage) begin
        // The next stage's input product is the one just used for the state update.
        cur_r <= y_r;
        y_r   <= y_new;
      end else if (!partial) begin
        ap_r <= y_r;
      end
    end
    if (state_r == S_BFIN) begin
      ap_r <= SIG_W'(blend_sum);
    end
    if (state_r == S_OUTF && out_free) begin
      out_sample_r <= sat_sample(WIDE_W'(out_sum));
    end
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

  // The stage counter never runs past the stages selected for this sample.
  a_stage_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (k_r < n_run))
    else $error("stage counter beyond active stage count");

  // A new result appears only out of the final output step.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_OUTF))
    else $error("result raised outside the output step");

  // An accepted transaction always starts the cascade at stage zero.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_MUL && k_r == '0))
    else $error("cascade did not start at stage zero");

endmodule

// ----- rtl/core/apc_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module apc_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ----- bench/tb_allpass_cascade_dispersion.sv -----
// Testbench for the allpass dispersion cascade: directed, random and backpressure tests.
`timescale 1ns / 1ps
module tb_allpass_cascade_dispersion;
  import apc_pkg::*;

  localparam int  STAGES    = 16;
  localparam longint SIG_HI = 524287;
  localparam longint SIG_LO = -524288;
  // Byte addresses of the two registers: the register index sits on address bit 2.
  localparam logic [ADDR_W-1:0] ADDR_STAGE_AMOUNT = {REG_STAGE_AMOUNT, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_ALLPASS_COEF = {REG_ALLPASS_COEF, 2'b00};
  // Margin for a full cascade with a blended stage to settle.
  localparam int  SETTLE    = 48;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic    in_valid = 1'b0;
  logic    in_stall;
  sample_t in_sample_in = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  sample_t out_sample_out;

  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  allpass_cascade_dispersion #(.MAX_STAGES(STAGES)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_sample_in(in_sample_in),
    .out_valid(out_valid), .out_stall(out_stall), .out_sample_out(out_sample_out),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Shadow copy of the cascade: one Q5.15 state word per stage plus both registers.
  longint stage_state [STAGES];
  longint amount_shadow;
  longint coef_shadow;

  // Output samples the cascade must produce, oldest first.
  sample_t expected_samples[$];
  int      errors = 0;

  // Idle controls shared between the stimulus and the result side.
  bit quiet_sender   = 1'b0;
  bit quiet_receiver = 1'b0;
  int hold_request   = 0;

  // Round half up, then floor shift, on a signed value.
  function automatic longint round_half_up(longint p, int sh);
    return (p + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // One first-order allpass section: y = c*x + s, then s = x - c*y.
  function automatic longint allpass_section(longint v, int k);
    longint y;
    y = clamp(round_half_up(coef_shadow * v, 15) + stage_state[k], SIG_LO, SIG_HI);
    stage_state[k] = clamp(v - round_half_up(coef_shadow * y, 15), SIG_LO, SIG_HI);
    return y;
  endfunction

  // Runs one sample through the shadow cascade and returns the mixed output.
  function automatic sample_t cascade_output(sample_t s);
    longint x, y, ys, acc, whole, frac;
    x = longint'(s);
    whole = amount_shadow >> FRAC_W;
    frac  = amount_shadow & 255;
    // Whole count at or past the last stage: clamp it and drop the blended stage.
    if (whole >= STAGES) begin
      whole = STAGES;
      frac  = 0;
    end
    y = x;
    for (int k = 0; k < whole; k++) y = allpass_section(y, k);
    // The next stage always runs and updates its state, even with a zero fraction.
    if (whole < STAGES) begin
      ys = allpass_section(y, int'(whole));
      y  = round_half_up(frac * ys + (256 - frac) * y, 8);
    end
    acc = clamp(round_half_up(x * 16384 + y * longint'(OUT_AP_GAIN), 15), -32768, 32767);
    return sample_t'(acc);
  endfunction

  // Pause length for either side: mostly none, sometimes short, now and then long.
  function automatic int pause_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(12, 45);
  endfunction

  // Offers one sample and holds it until the transaction completes. The valid stays
  // high into the next call when no gap follows, so it is never dropped and raised
  // within one time step.
  task automatic send_sample(input sample_t s);
    int gap;
    in_valid     <= 1'b1;
    in_sample_in <= s;
    do @(posedge clk); while (in_stall);
    expected_samples.push_back(cascade_output(s));
    gap = quiet_sender ? 0 : pause_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Setup cycle, then access cycle; the register takes the value at the edge with pready.
  // The bus then idles before the task returns, so a following write starts at a later edge.
  task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_STAGE_AMOUNT) amount_shadow = longint'(data[AMT_W-1:0]);
    else coef_shadow = longint'($signed(data[SAMPLE_W-1:0]));
    @(posedge clk);
  endtask

  // Registers change only while the cascade is idle, so drain every transaction first.
  task automatic configure(input int amount, input sample_t coef);
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    @(posedge clk);
    reg_write(ADDR_STAGE_AMOUNT, DATA_W'(amount));
    reg_write(ADDR_ALLPASS_COEF, {{(DATA_W-SAMPLE_W){coef[SAMPLE_W-1]}}, coef});
  endtask

  function automatic sample_t random_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return sample_t'($urandom_range(0, 65535));
    if (r < 85) return sample_t'($urandom_range(0, 1) ? 32767 : -32768);
    return sample_t'(int'($urandom_range(0, 512)) - 256);
  endfunction

  // Stage amount biased toward the corners: zero, the clamped maximum, and the
  // two fraction extremes around a random whole count.
  function automatic int random_amount();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return 0;
    if (r < 25) return 4096;
    if (r < 37) return $urandom_range(0, 15) << FRAC_W;
    if (r < 49) return ($urandom_range(0, 15) << FRAC_W) | 255;
    return $urandom_range(0, 4096);
  endfunction

  function automatic sample_t random_coef();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'sh7FFF;
    if (r < 20) return 16'sh8000;
    if (r < 25) return '0;
    return sample_t'($urandom_range(0, 65535));
  endfunction

  // Registers straight out of reset are zero: a zero fraction on stage 0 still
  // updates its state, but the blend passes the sample itself on to the output gain.
  task automatic test_reset_defaults();
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh0001);
    send_sample(16'shFFFF);
  endtask

  // Extremes of every field, the clamped maximum stage count, and both fraction ends.
  task automatic test_directed_corners();
    configure(4096, 16'sh7FFF);
    send_sample(16'sh7FFF);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh8000);
    configure(4096, 16'sh8000);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
    configure(15 * 256 + 255, 16'sh4000);
    send_sample(16'sh7FFF);
    send_sample(16'sh0000);
    send_sample(16'sh8000);
    configure(1 * 256 + 128, 16'shC000);
    send_sample(16'sh1234);
    send_sample(16'shEDCC);
    configure(3 * 256, 16'sh2000);
    send_sample(16'sh7FFF);
    send_sample(16'sh0000);
    configure(255, 16'sh0000);
    send_sample(16'sh5555);
    send_sample(16'shAAAA);
  endtask

  // Random settings, each followed by a batch of random samples. Of every four phases,
  // three run one side or both without idling.
  task automatic test_random_phases();
    for (int phase = 0; phase < 18; phase++) begin
      configure(random_amount(), random_coef());
      quiet_sender   = (phase % 4 == 1) || (phase % 4 == 3);
      quiet_receiver = (phase % 4 == 2) || (phase % 4 == 3);
      for (int n = 0; n < 100; n++) send_sample(random_sample());
    end
    quiet_sender   = 1'b0;
    quiet_receiver = 1'b0;
  endtask

  // The receiver holds off for a long stretch while samples keep coming, so the
  // result register fills and the input stalls.
  task automatic test_output_backpressure();
    configure(4096, 16'sh6000);
    quiet_sender = 1'b1;
    hold_request = 400;
    for (int n = 0; n < 24; n++) send_sample(random_sample());
    quiet_sender = 1'b0;
  endtask

  initial begin : stimulus
    for (int k = 0; k < STAGES; k++) stage_state[k] = 0;
    amount_shadow = 0;
    coef_shadow   = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_directed_corners();
    test_random_phases();
    test_output_backpressure();

    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && expected_samples.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Checks each completed result transaction against the oldest expected sample,
  // then decides whether to stall the next cycle. A hold request takes priority.
  initial begin : result_checker
    int      stall_left;
    sample_t want;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got %0d", $time, out_sample_out);
        end else begin
          want = expected_samples.pop_front();
          if (out_sample_out !== want) begin
            errors++;
            $display("%0t: sample_out mismatch, expected %0d, got %0d",
                     $time, want, out_sample_out);
          end
        end
      end
      if (hold_request > 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end else if (stall_left == 0 && !quiet_receiver) begin
        stall_left = pause_length();
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Hard stop well beyond the slowest legal run.
  initial begin : watchdog
    #10ms;
    $display("tb: failure");
    $finish;
  end

endmodule
